// File: rtl/pal_pkg.sv
// Shared types, constants and the fixed fuse map of the programmable AND-OR array.
package pal_pkg;

   localparam int PINS          = 8;
   localparam int TERMS         = 64;
   localparam int COLS          = 32;
   localparam int TERMS_PER_PIN = 8;
   localparam int DATA_W        = 6;
   localparam int INDEX_W       = $clog2(PINS);

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_READ  = 1'b1
   } action_type;

   typedef struct packed {
      action_type        action;
      logic [INDEX_W-1:0] pin_index;
      logic              pin_level;
   } req_type;

   // Input pins all high and zero feedback give every pin but pin 12 a high level.
   localparam logic [PINS-1:0] INPUT_RESET    = 8'hFF;
   localparam logic [PINS-1:0] FEEDBACK_RESET = 8'h7F;

   // One row per product term; a set bit is a blown fuse.
   localparam logic [COLS-1:0] FUSE_MAP [TERMS] = '{
      32'hFFFFFFFF, 32'hFBB7B7BF, 32'h00000000, 32'h00000000,
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
      32'hFFFFFFBB, 32'h00000000, 32'h00000000, 32'h00000000,
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
      32'hFFFFFBBB, 32'hFFFFF77B, 32'h00000000, 32'h00000000,
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
      32'hFFFFBBBB, 32'hFFFF7F7B, 32'hFFFF77FB, 32'h00000000,
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
      32'hFFFBBBBB, 32'hFFF7FF7B, 32'hFFF7F7FB, 32'hFFF77FFB,
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
      32'hFFBBBBBB, 32'hFF7FFF7B, 32'hFF7FF7FB, 32'hFF7F7FFB,
      32'hFF77FFFB, 32'h00000000, 32'h00000000, 32'h00000000,
      32'hFBBBBBBB, 32'hF7FFFF7B, 32'hF7FFF7FB, 32'hF7FF7FFB,
      32'hF7F7FFFB, 32'hF77FFFFB, 32'h00000000, 32'h00000000,
      32'hFFFFFFFF, 32'hEFFFFFFF, 32'h00000000, 32'h00000000,
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
   };

endpackage

// File: rtl/pal_req_stage.sv
// Input register stage that holds one accepted transaction until the array takes it.
module pal_req_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [pal_pkg::INDEX_W-1:0]     req_pin_index,
   input  logic                            req_pin_level,
   input  logic                            stage_take,
   output logic                            stage_valid,
   output pal_pkg::req_type                stage_req
);

   logic             valid_ff;
   logic             valid_in;
   pal_pkg::req_type req_ff;
   pal_pkg::req_type req_in;

   assign req_ready = !valid_ff || stage_take;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_comb begin
      req_in = req_ff;
      if (req_ready && req_valid) begin
         req_in.action    = pal_pkg::action_type'(req_action);
         req_in.pin_index = req_pin_index;
         req_in.pin_level = req_pin_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   assign stage_valid = valid_ff;
   assign stage_req   = req_ff;

endmodule

// File: rtl/pal_plane.sv
// Combinational AND-OR plane: columns, product terms, output enables and inversion.
module pal_plane (
   input  logic [pal_pkg::PINS-1:0] input_levels,
   input  logic [pal_pkg::PINS-1:0] feedback_levels,
   output logic [pal_pkg::PINS-1:0] next_levels
);

   logic [pal_pkg::COLS-1:0]  cols;
   logic [pal_pkg::TERMS-1:0] terms;

   always_comb begin
      for (int k = 0; k < pal_pkg::PINS; k++) begin
         cols[4*k]     = input_levels[k];
         cols[4*k + 1] = !input_levels[k];
         cols[4*k + 2] = feedback_levels[k];
         cols[4*k + 3] = !feedback_levels[k];
      end
   end

   // A term is true when every connected column is high.
   always_comb begin
      for (int r = 0; r < pal_pkg::TERMS; r++) begin
         terms[r] = ((~cols & ~pal_pkg::FUSE_MAP[r]) == '0);
      end
   end

   // The first and last pins use their first term as an output enable.
   always_comb begin
      logic [pal_pkg::TERMS_PER_PIN-1:0] group;
      logic                              gated;
      logic                              sum;
      logic                              enabled;
      for (int k = 0; k < pal_pkg::PINS; k++) begin
         group   = terms[k*pal_pkg::TERMS_PER_PIN +: pal_pkg::TERMS_PER_PIN];
         gated   = (k == 0) || (k == pal_pkg::PINS - 1);
         sum     = gated ? |group[pal_pkg::TERMS_PER_PIN-1:1] : |group;
         enabled = gated ? group[0] : 1'b1;
         next_levels[k] = enabled && !sum;
      end
   end

endmodule

// File: rtl/pal_and_or_array_evaluator.sv
// Top level of the programmable AND-OR array bus peripheral.
// Usage:
//   The req_ channel carries one bus transaction per handshake. A write
//   transaction (req_action low) sets input pin req_pin_index to
//   req_pin_level and produces no response. A read transaction evaluates the
//   64 product terms over the input pins and the latched output pins, latches
//   the eight new pin levels as feedback, and returns pins 13 to 18 on
//   rsp_read_data (bit 0 is pin 13).
//   A transaction is registered in the input register on acceptance and
//   processed from there; a read result passes the AND-OR plane into the
//   response register, which drives rsp_valid. One transaction per cycle is
//   taken while no read waits in the input register on a stalled response.
//   When the receiver stalls, the response register holds and a read waiting
//   in the input register holds too, so req_ready drops; writes keep flowing
//   past a stalled response.
//   Reset sets all input pins high and loads the feedback with the result of
//   one evaluation from zero feedback; a transaction or response still held is dropped.
module pal_and_or_array_evaluator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [pal_pkg::INDEX_W-1:0]         req_pin_index,
   input  logic                                req_pin_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pal_pkg::DATA_W-1:0]          rsp_read_data
);

   logic                            stage_valid;
   pal_pkg::req_type                stage_req;
   logic                            stage_take;
   logic                            slot_free;
   logic                            write_commit;
   logic                            read_commit;
   logic [pal_pkg::PINS-1:0]        next_levels;
   logic [pal_pkg::DATA_W-1:0]      next_data;
   logic [pal_pkg::DATA_W-1:0]      held_data;

   logic [pal_pkg::PINS-1:0]        input_levels_ff;
   logic [pal_pkg::PINS-1:0]        input_levels_in;
   logic [pal_pkg::PINS-1:0]        feedback_ff;
   logic [pal_pkg::PINS-1:0]        feedback_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [pal_pkg::DATA_W-1:0]      rsp_data_ff;
   logic [pal_pkg::DATA_W-1:0]      rsp_data_in;

   pal_req_stage u_req_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_pin_index (req_pin_index),
      .req_pin_level (req_pin_level),
      .stage_take    (stage_take),
      .stage_valid   (stage_valid),
      .stage_req     (stage_req)
   );

   pal_plane u_plane (
      .input_levels    (input_levels_ff),
      .feedback_levels (feedback_ff),
      .next_levels     (next_levels)
   );

   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign stage_take   = (stage_req.action == pal_pkg::ACT_WRITE) || slot_free;
   assign write_commit = stage_valid && (stage_req.action == pal_pkg::ACT_WRITE);
   assign read_commit  = stage_valid && (stage_req.action == pal_pkg::ACT_READ) && slot_free;

   // Read data lists the pins from pin 13 upward, which is feedback bit 6 downward.
   always_comb begin
      for (int j = 0; j < pal_pkg::DATA_W; j++) begin
         next_data[j] = next_levels[pal_pkg::DATA_W - j];
         held_data[j] = feedback_ff[pal_pkg::DATA_W - j];
      end
   end

   always_comb begin
      input_levels_in = input_levels_ff;
      if (write_commit) begin
         input_levels_in[stage_req.pin_index] = stage_req.pin_level;
      end
   end

   assign feedback_in  = read_commit ? next_levels : feedback_ff;
   assign rsp_valid_in = read_commit || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = read_commit ? next_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_levels_ff <= pal_pkg::INPUT_RESET;
         feedback_ff     <= pal_pkg::FEEDBACK_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         input_levels_ff <= input_levels_in;
         feedback_ff     <= feedback_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   a_read_gives_response: assert property (@(posedge clock) disable iff (reset)
      read_commit |=> rsp_valid_ff)
      else $error("A committed read transaction did not produce a response.");

   a_write_keeps_feedback: assert property (@(posedge clock) disable iff (reset)
      write_commit |=> $stable(feedback_ff))
      else $error("A write transaction changed the feedback levels.");

   a_only_write_sets_inputs: assert property (@(posedge clock) disable iff (reset)
      !write_commit |=> $stable(input_levels_ff))
      else $error("Input pin levels changed without a write transaction.");

   a_response_matches_feedback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff == held_data))
      else $error("Pending response does not match the latched feedback levels.");

   a_stalled_read_held: assert property (@(posedge clock) disable iff (reset)
      stage_valid && (stage_req.action == pal_pkg::ACT_READ) && !slot_free |=> stage_valid)
      else $error("A stalled read transaction was dropped from the input register.");

endmodule

// File: tb/tb_pal_and_or_array_evaluator.sv
// Self-checking testbench for the programmable AND-OR array bus peripheral.
module tb_pal_and_or_array_evaluator;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      pal_pkg::action_type                act;
      logic [pal_pkg::INDEX_W-1:0]        idx;
      logic                               lvl;
      logic                               typed;
      logic [pal_pkg::DATA_W-1:0]         data;
   } bus_op_type;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_OPS    = 1925;

   // Fuse rows of the array; a set bit disconnects that column from the term.
   localparam logic [31:0] PAL_FUSES [64] = '{
      32'hFFFFFFFF, 32'hFBB7B7BF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'hFFFFFFBB, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'hFFFFFBBB, 32'hFFFFF77B, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'hFFFFBBBB, 32'hFFFF7F7B, 32'hFFFF77FB, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'hFFFBBBBB, 32'hFFF7FF7B, 32'hFFF7F7FB, 32'hFFF77FFB, 32'h0, 32'h0, 32'h0, 32'h0,
      32'hFFBBBBBB, 32'hFF7FFF7B, 32'hFF7FF7FB, 32'hFF7F7FFB, 32'hFF77FFFB,
      32'h0, 32'h0, 32'h0,
      32'hFBBBBBBB, 32'hF7FFFF7B, 32'hF7FFF7FB, 32'hF7FF7FFB, 32'hF7F7FFFB,
      32'hF77FFFFB, 32'h0, 32'h0,
      32'hFFFFFFFF, 32'hEFFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
   };

   // The first two reads after reset are typed in; the rest use the predictor.
   localparam bus_op_type DIRECTED_OPS [DIRECTED_ROWS] = '{
      '{pal_pkg::ACT_READ,  3'd0, 1'b0, 1'b1, 6'h00},
      '{pal_pkg::ACT_READ,  3'd0, 1'b0, 1'b1, 6'h20},
      '{pal_pkg::ACT_WRITE, 3'd7, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_READ,  3'd0, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_READ,  3'd7, 1'b1, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd0, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd1, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd2, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd3, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_READ,  3'd0, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd4, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd5, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd6, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_READ,  3'd0, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_READ,  3'd0, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd0, 1'b1, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd1, 1'b1, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd2, 1'b1, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd3, 1'b1, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd4, 1'b1, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd5, 1'b1, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd6, 1'b1, 1'b0, 6'h00},
      '{pal_pkg::ACT_WRITE, 3'd7, 1'b1, 1'b0, 6'h00},
      '{pal_pkg::ACT_READ,  3'd0, 1'b0, 1'b0, 6'h00},
      '{pal_pkg::ACT_READ,  3'd0, 1'b0, 1'b0, 6'h00}
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_action = pal_pkg::ACT_WRITE;
   logic [pal_pkg::INDEX_W-1:0]   req_pin_index = '0;
   logic                          req_pin_level = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [pal_pkg::DATA_W-1:0]    rsp_read_data;

   logic                          op_typed = 1'b0;
   logic [pal_pkg::DATA_W-1:0]    op_typed_data = '0;
   logic                          calm = 1'b0;

   logic [pal_pkg::PINS-1:0]      pin_inputs;
   logic [pal_pkg::PINS-1:0]      pin_feedback;
   logic [pal_pkg::DATA_W-1:0]    read_data_q[$];
   logic [pal_pkg::DATA_W-1:0]    wanted_data;
   int                            mismatch_count = 0;

   pal_and_or_array_evaluator uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_pin_index (req_pin_index),
      .req_pin_level (req_pin_level),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_data (rsp_read_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("[pal_and_or_array_evaluator] ERROR");
      $finish;
   end

   function automatic logic [pal_pkg::PINS-1:0] pal_next_levels(
      input logic [pal_pkg::PINS-1:0] pins_in,
      input logic [pal_pkg::PINS-1:0] fb);
      logic [31:0]              cols;
      logic [pal_pkg::PINS-1:0] levels;
      logic                     any_term;
      logic                     enable;
      logic                     hit;
      cols = '0;
      for (int k = 0; k < pal_pkg::PINS; k++) begin
         cols[4*k +: 4] = {~fb[k], fb[k], ~pins_in[k], pins_in[k]};
      end
      levels = '0;
      for (int k = 0; k < pal_pkg::PINS; k++) begin
         any_term = 1'b0;
         enable = 1'b1;
         for (int r = 0; r < 8; r++) begin
            hit = ((~cols & ~PAL_FUSES[8*k + r]) == 32'd0);
            if (r == 0 && (k == 0 || k == pal_pkg::PINS - 1)) begin
               enable = hit;
            end else if (hit) begin
               any_term = 1'b1;
            end
         end
         levels[k] = enable & ~any_term;
      end
      return levels;
   endfunction

   function automatic logic [pal_pkg::DATA_W-1:0] pins_13_to_18(
      input logic [pal_pkg::PINS-1:0] levels);
      return {levels[1], levels[2], levels[3], levels[4], levels[5], levels[6]};
   endfunction

   task automatic issue_transaction(input bus_op_type op);
      while (!calm && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= op.act;
      req_pin_index <= op.idx;
      req_pin_level <= op.lvl;
      op_typed <= op.typed;
      op_typed_data <= op.data;
      do @(posedge clock); while (!req_ready);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= ($urandom_range(0, 1) == 1);
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 10);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         pin_inputs = 8'hFF;
         pin_feedback = pal_next_levels(8'hFF, 8'h00);
         read_data_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_action == pal_pkg::ACT_WRITE) begin
               pin_inputs[req_pin_index] = req_pin_level;
            end else begin
               pin_feedback = pal_next_levels(pin_inputs, pin_feedback);
               read_data_q.push_back(op_typed ? op_typed_data : pins_13_to_18(pin_feedback));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (read_data_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected read response: data=%h", rsp_read_data);
               end
            end else begin
               wanted_data = read_data_q.pop_front();
               if (rsp_read_data !== wanted_data) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("read_data mismatch: expected=%h actual=%h",
                              wanted_data, rsp_read_data);
                  end
               end
            end
         end
      end
   end

   initial begin
      bus_op_type  op;
      int unsigned pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (DIRECTED_OPS[i]) begin
         issue_transaction(DIRECTED_OPS[i]);
      end
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n == 700) begin
            calm <= 1'b1;
         end else if (n == 1100) begin
            calm <= 1'b0;
         end
         op.act = ($urandom_range(0, 99) < 45) ? pal_pkg::ACT_READ : pal_pkg::ACT_WRITE;
         pick = $urandom_range(0, pal_pkg::PINS - 1);
         op.idx = pick[pal_pkg::INDEX_W-1:0];
         op.lvl = ($urandom_range(0, 1) == 1);
         op.typed = 1'b0;
         op.data = '0;
         issue_transaction(op);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (read_data_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[pal_and_or_array_evaluator] OK");
      end else begin
         $display("[pal_and_or_array_evaluator] ERROR");
      end
      $finish;
   end

endmodule
